// ===== hw/rtl/lfg_pkg.sv =====
// shared types, widths and register codes of the longest free gap search
package lfg_pkg;

  localparam int RANGE_W             = 16;
  localparam int IDX_W               = 12;
  localparam int MINRUN_W            = 13;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 16;
  localparam int MAX_SAMPLES_DEFAULT = 4096;

  localparam logic [RANGE_W-1:0]  THRESHOLD_RESET = RANGE_W'(2000);
  localparam logic [MINRUN_W-1:0] MIN_RUN_RESET   = MINRUN_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISTANCE_THRESHOLD = 2'd0,
    REG_MIN_RUN_LENGTH     = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [RANGE_W-1:0]  distance_threshold_mm;
    logic [MINRUN_W-1:0] min_run_length;
  } cfg_t;

  typedef struct packed {
    logic               gap_found;
    logic [IDX_W-1:0]   gap_start;
    logic [IDX_W-1:0]   gap_end;
    logic [IDX_W-1:0]   aim_index;
    logic [RANGE_W-1:0] target_range_mm;
  } result_t;

endpackage

// ===== hw/rtl/lfg_if.sv =====
// handshake interfaces for samples, results and configuration writes
interface lfg_sample_if;
  logic                         valid;
  logic                         ready;
  logic [lfg_pkg::RANGE_W-1:0]  range_mm;
  logic                         last_sample;

  modport source (output valid, range_mm, last_sample, input ready);
  modport sink (input valid, range_mm, last_sample, output ready);
endinterface

interface lfg_result_if;
  logic                         valid;
  logic                         ready;
  logic                         gap_found;
  logic [lfg_pkg::IDX_W-1:0]    gap_start;
  logic [lfg_pkg::IDX_W-1:0]    gap_end;
  logic [lfg_pkg::IDX_W-1:0]    aim_index;
  logic [lfg_pkg::RANGE_W-1:0]  target_range_mm;

  modport source (output valid, gap_found, gap_start, gap_end, aim_index,
                  target_range_mm, input ready);
  modport sink (input valid, gap_found, gap_start, gap_end, aim_index,
                target_range_mm, output ready);
endinterface

interface lfg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lfg_pkg::CFG_IDX_W-1:0] index;
  logic [lfg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lfg_cfg_regs.sv =====
// configuration registers: distance threshold and minimum run length
module lfg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [lfg_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [lfg_pkg::CFG_DATA_W-1:0] wr_data,
  output lfg_pkg::cfg_t                  cfg
);
  import lfg_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.distance_threshold_mm <= THRESHOLD_RESET;
      regs.min_run_length        <= MIN_RUN_RESET;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_DISTANCE_THRESHOLD: regs.distance_threshold_mm <= wr_data[RANGE_W-1:0];
        REG_MIN_RUN_LENGTH:     regs.min_run_length <= wr_data[MINRUN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== hw/rtl/lfg_scan_tracker.sv =====
// per-scan run tracking, best gap selection and result forming
module lfg_scan_tracker #(
  parameter int MAX_SAMPLES = lfg_pkg::MAX_SAMPLES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [lfg_pkg::RANGE_W-1:0]  range_mm,
  input  logic                         last_sample,
  input  lfg_pkg::cfg_t                cfg,
  output lfg_pkg::result_t             result
);
  import lfg_pkg::*;

  localparam int LEN_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (LEN_W > MINRUN_W) ? LEN_W : MINRUN_W;

  logic [LEN_W-1:0]   sample_count, sample_count_next;
  logic [LEN_W-1:0]   run_length, run_length_next;
  logic [IDX_W-1:0]   run_start, run_start_next;
  logic [RANGE_W-1:0] run_peak, run_peak_next;
  logic [IDX_W-1:0]   run_peak_index, run_peak_index_next;
  logic [LEN_W-1:0]   run_tie_count, run_tie_count_next;
  logic [LEN_W-1:0]   best_length, best_length_next;
  logic [IDX_W-1:0]   best_start, best_start_next;
  logic [IDX_W-1:0]   best_end, best_end_next;
  logic [RANGE_W-1:0] best_peak, best_peak_next;
  logic [IDX_W-1:0]   best_peak_index, best_peak_index_next;
  logic [LEN_W-1:0]   best_tie_count, best_tie_count_next;

  logic             in_window;
  logic             is_free;
  logic [LEN_W-1:0] run_inc;
  logic [IDX_W-1:0] idx;

  assign in_window = sample_count < LEN_W'(MAX_SAMPLES);
  assign is_free   = range_mm >= cfg.distance_threshold_mm;
  assign run_inc   = run_length + LEN_W'(1);
  assign idx       = IDX_W'(sample_count);

  always_comb begin
    sample_count_next    = sample_count;
    run_length_next      = run_length;
    run_start_next       = run_start;
    run_peak_next        = run_peak;
    run_peak_index_next  = run_peak_index;
    run_tie_count_next   = run_tie_count;
    best_length_next     = best_length;
    best_start_next      = best_start;
    best_end_next        = best_end;
    best_peak_next       = best_peak;
    best_peak_index_next = best_peak_index;
    best_tie_count_next  = best_tie_count;

    // samples past the window neither extend nor break a run
    if (in_window) begin
      sample_count_next = sample_count + LEN_W'(1);
      if (!is_free) begin
        run_length_next = '0;
      end else begin
        run_length_next = run_inc;
        if (run_length == '0) begin
          run_start_next      = idx;
          run_peak_next       = range_mm;
          run_peak_index_next = idx;
          run_tie_count_next  = LEN_W'(1);
        end else begin
          if (range_mm > run_peak) begin
            run_peak_next       = range_mm;
            run_peak_index_next = idx;
            run_tie_count_next  = LEN_W'(1);
          end else if (range_mm == run_peak) begin
            run_tie_count_next = run_tie_count + LEN_W'(1);
          end
          // strict compare keeps the earliest run on equal lengths
          if (CMP_W'(run_inc) >= CMP_W'(cfg.min_run_length) && run_inc > best_length) begin
            best_length_next     = run_inc;
            best_start_next      = run_start;
            best_end_next        = idx;
            best_peak_next       = run_peak_next;
            best_peak_index_next = run_peak_index_next;
            best_tie_count_next  = run_tie_count_next;
          end
        end
      end
    end
  end

  always_comb begin
    result = '0;
    if (best_length_next != '0) begin
      result.gap_found       = 1'b1;
      result.gap_start       = best_start_next;
      result.gap_end         = best_end_next;
      result.aim_index       = best_peak_index_next + IDX_W'(best_tie_count_next >> 1);
      result.target_range_mm = best_peak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_sample)) begin
      sample_count    <= '0;
      run_length      <= '0;
      run_start       <= '0;
      run_peak        <= '0;
      run_peak_index  <= '0;
      run_tie_count   <= '0;
      best_length     <= '0;
      best_start      <= '0;
      best_end        <= '0;
      best_peak       <= '0;
      best_peak_index <= '0;
      best_tie_count  <= '0;
    end else if (step) begin
      sample_count    <= sample_count_next;
      run_length      <= run_length_next;
      run_start       <= run_start_next;
      run_peak        <= run_peak_next;
      run_peak_index  <= run_peak_index_next;
      run_tie_count   <= run_tie_count_next;
      best_length     <= best_length_next;
      best_start      <= best_start_next;
      best_end        <= best_end_next;
      best_peak       <= best_peak_next;
      best_peak_index <= best_peak_index_next;
      best_tie_count  <= best_tie_count_next;
    end
  end

endmodule

// ===== hw/rtl/longest_free_gap_target_search.sv =====
// top level of the longest free gap search: input register, tracker, result register
//
// Takes one range sample per clock and, on the sample flagged last, delivers one result
// with the longest free run of the scan (earliest on ties), its peak range and the target
// index. A taken sample sits in the input register, from which the tracker updates the run
// and best-gap registers, and the result of a scan is registered when its last sample leaves
// the input register. Throughput is one sample per cycle, one tracker update per sample;
// the input side only waits when a last sample reaches the tracker while the previous
// result is still not taken. Configuration is written through the cfg channel, which is
// always ready, and should only change between scans.
module longest_free_gap_target_search #(
  parameter int MAX_SAMPLES = lfg_pkg::MAX_SAMPLES_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  lfg_sample_if.sink   samples,
  lfg_result_if.source results,
  lfg_cfg_if.sink      cfg
);
  import lfg_pkg::*;

  logic               in_valid;
  logic [RANGE_W-1:0] in_range;
  logic               in_last;
  logic               consume;
  logic               res_valid;
  result_t            res;
  result_t            tracker_result;
  cfg_t               cfg_regs;

  // a non-last sample never needs the result register
  assign consume       = in_valid && (!in_last || !res_valid || results.ready);
  assign samples.ready = !in_valid || consume;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_range <= samples.range_mm;
      in_last  <= samples.last_sample;
    end
  end

  lfg_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  lfg_scan_tracker #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_scan_tracker (
    .clk         (clk),
    .rst         (rst),
    .step        (consume),
    .range_mm    (in_range),
    .last_sample (in_last),
    .cfg         (cfg_regs),
    .result      (tracker_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (consume && in_last) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last) begin
      res <= tracker_result;
    end
  end

  assign results.valid           = res_valid;
  assign results.gap_found       = res.gap_found;
  assign results.gap_start       = res.gap_start;
  assign results.gap_end         = res.gap_end;
  assign results.aim_index       = res.aim_index;
  assign results.target_range_mm = res.target_range_mm;

endmodule

// ===== hw/rtl/lfg_checker.sv =====
// port-level checks on the longest free gap search, bound to the top level
module lfg_checker #(
  parameter int MAX_SAMPLES = lfg_pkg::MAX_SAMPLES_DEFAULT
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         gap_found,
  input logic [lfg_pkg::IDX_W-1:0]    gap_start,
  input logic [lfg_pkg::IDX_W-1:0]    gap_end,
  input logic [lfg_pkg::IDX_W-1:0]    aim_index,
  input logic [lfg_pkg::RANGE_W-1:0]  target_range_mm
);
  import lfg_pkg::*;

  // a held result keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(gap_found) && $stable(gap_start)
      && $stable(gap_end) && $stable(aim_index) && $stable(target_range_mm))
    else $error("result changed while stalled");

  // no gap means all fields read zero
  a_no_gap_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !gap_found |-> gap_start == '0 && gap_end == '0
      && aim_index == '0 && target_range_mm == '0)
    else $error("non-zero fields on a result without a gap");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // with indices that never wrap, a gap spans at least two samples and holds its target
  if (MAX_SAMPLES <= (1 << IDX_W)) begin : g_order
    a_gap_order: assert property (@(posedge clk) disable iff (rst)
      res_valid && gap_found |-> gap_start < gap_end && gap_start <= aim_index
        && aim_index <= gap_end)
      else $error("gap bounds or target out of order");
  end

endmodule

bind longest_free_gap_target_search lfg_checker #(
  .MAX_SAMPLES (MAX_SAMPLES)
) u_lfg_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (results.valid),
  .res_ready       (results.ready),
  .gap_found       (results.gap_found),
  .gap_start       (results.gap_start),
  .gap_end         (results.gap_end),
  .aim_index       (results.aim_index),
  .target_range_mm (results.target_range_mm)
);

// ===== bench/longest_free_gap_target_search_tb.sv =====
`timescale 1ns / 100ps
// testbench of the longest free gap search: scan stimulus, gap prediction and result checks
module longest_free_gap_target_search_tb;
  import lfg_pkg::*;

  localparam int SCAN_LIMIT    = MAX_SAMPLES_DEFAULT;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int RANDOM_SCANS  = 40;

  typedef enum int {READY_ALWAYS, READY_PATTERN, READY_RANDOM} ready_mode_t;

  logic clk = 1'b0;
  logic rst;

  lfg_sample_if smp ();
  lfg_result_if res ();
  lfg_cfg_if    cfg_ch ();

  longest_free_gap_target_search u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (smp),
    .results (res),
    .cfg     (cfg_ch)
  );

  always #6 clk = ~clk;

  // predicted registers and scan state
  logic [RANGE_W-1:0] thr_mm;
  int unsigned min_run;
  int unsigned scan_idx, run_len, run_first, run_peak, run_peak_idx, run_ties;
  int unsigned gap_len, gap_first, gap_last, gap_peak, gap_peak_idx, gap_ties;

  result_t            gap_results_q[$];
  logic [RANGE_W-1:0] scan_buf[$];
  int                 fail_count = 0;

  bit          sender_idle;
  int          burst_left;
  ready_mode_t stall_mode;
  logic [7:0]  stall_pat;
  logic [2:0]  stall_phase = '0;

  always @(posedge clk) begin
    stall_phase <= stall_phase + 3'd1;
    case (stall_mode)
      READY_PATTERN: res.ready <= stall_pat[stall_phase];
      READY_RANDOM: res.ready <= ($urandom_range(3, 0) != 0);
      default: res.ready <= 1'b1;
    endcase
  end

  function automatic void clear_scan_state();
    scan_idx = 0;
    run_len = 0;
    run_first = 0;
    run_peak = 0;
    run_peak_idx = 0;
    run_ties = 0;
    gap_len = 0;
    gap_first = 0;
    gap_last = 0;
    gap_peak = 0;
    gap_peak_idx = 0;
    gap_ties = 0;
  endfunction

  function automatic void predict_sample(input logic [RANGE_W-1:0] r, input logic is_last);
    result_t gap_res;
    // samples past the scan limit leave the runs alone
    if (scan_idx < SCAN_LIMIT) begin
      if (r < thr_mm) begin
        run_len = 0;
      end else begin
        run_len++;
        if (run_len == 1) begin
          run_first = scan_idx;
          run_peak = 32'(r);
          run_peak_idx = scan_idx;
          run_ties = 1;
        end else begin
          if (r > run_peak) begin
            run_peak = 32'(r);
            run_peak_idx = scan_idx;
            run_ties = 1;
          end else if (r == run_peak) begin
            run_ties++;
          end
          if (run_len >= min_run && run_len > gap_len) begin
            gap_len = run_len;
            gap_first = run_first;
            gap_last = scan_idx;
            gap_peak = run_peak;
            gap_peak_idx = run_peak_idx;
            gap_ties = run_ties;
          end
        end
      end
      scan_idx++;
    end
    if (is_last) begin
      gap_res = '0;
      if (gap_len != 0) begin
        gap_res.gap_found = 1'b1;
        gap_res.gap_start = IDX_W'(gap_first);
        gap_res.gap_end = IDX_W'(gap_last);
        gap_res.aim_index = IDX_W'(gap_peak_idx + gap_ties / 2);
        gap_res.target_range_mm = RANGE_W'(gap_peak);
      end
      gap_results_q.insert(gap_results_q.size(), gap_res);
      clear_scan_state();
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && res.valid && res.ready) begin
      got.gap_found = res.gap_found;
      got.gap_start = res.gap_start;
      got.gap_end = res.gap_end;
      got.aim_index = res.aim_index;
      got.target_range_mm = res.target_range_mm;
      if (gap_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: found %0b start %0d end %0d target %0d range %0d",
                   got.gap_found, got.gap_start, got.gap_end, got.aim_index,
                   got.target_range_mm);
      end else begin
        want = gap_results_q.pop_front();
        if (got.gap_found !== want.gap_found || got.gap_start !== want.gap_start ||
            got.gap_end !== want.gap_end || got.aim_index !== want.aim_index ||
            got.target_range_mm !== want.target_range_mm) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"gap mismatch: expected found %0b start %0d end %0d target %0d ",
                      "range %0d, got found %0b start %0d end %0d target %0d range %0d"},
                     want.gap_found, want.gap_start, want.gap_end, want.aim_index,
                     want.target_range_mm, got.gap_found, got.gap_start, got.gap_end,
                     got.aim_index, got.target_range_mm);
        end
      end
    end
  end

  task automatic send_sample(input logic [RANGE_W-1:0] r, input logic is_last);
    if (sender_idle && burst_left <= 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = $urandom_range(16, 1);
    end
    smp.valid <= 1'b1;
    smp.range_mm <= r;
    smp.last_sample <= is_last;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    burst_left--;
    predict_sample(r, is_last);
  endtask

  task automatic send_scan();
    foreach (scan_buf[i]) send_sample(scan_buf[i], i == scan_buf.size() - 1);
  endtask

  // let every expected gap come out and the pipeline empty
  task automatic wait_idle();
    smp.valid <= 1'b0;
    smp.last_sample <= 1'b0;
    while (gap_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DISTANCE_THRESHOLD: thr_mm = value;
      REG_MIN_RUN_LENGTH: min_run = 32'(value[MINRUN_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    // run of five with a tied peak, then a lone sample scan with no gap
    scan_buf = '{16'd2000, 16'd3000, 16'hFFFF, 16'd3000, 16'hFFFF, 16'd1999};
    send_scan();
    scan_buf = '{16'hFFFF};
    send_scan();
    wait_idle();
  endtask

  task automatic test_short_runs();
    // upper data bits fall outside the register
    write_reg(REG_DISTANCE_THRESHOLD, 16'd100);
    write_reg(REG_MIN_RUN_LENGTH, 16'hE001);
    scan_buf = '{16'd100, 16'd99, 16'd100};
    send_scan();
    scan_buf = '{16'd0, 16'd100, 16'd101};
    send_scan();
    wait_idle();
    write_reg(REG_MIN_RUN_LENGTH, 16'd0);
    scan_buf = '{16'd500, 16'd500};
    send_scan();
    wait_idle();
  endtask

  task automatic test_threshold_extremes();
    write_reg(REG_DISTANCE_THRESHOLD, 16'd0);
    write_reg(REG_MIN_RUN_LENGTH, 16'd2);
    scan_buf = '{16'd0, 16'd0, 16'd0};
    send_scan();
    wait_idle();
    write_reg(REG_DISTANCE_THRESHOLD, 16'hFFFF);
    scan_buf = '{16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF};
    send_scan();
    wait_idle();
  endtask

  task automatic test_earliest_tie();
    write_reg(REG_DISTANCE_THRESHOLD, 16'd1000);
    write_reg(REG_MIN_RUN_LENGTH, 16'd3);
    scan_buf = '{16'd1000, 16'd1500, 16'd1200, 16'd0, 16'd2000, 16'd2000, 16'd2000};
    send_scan();
    wait_idle();
  endtask

  task automatic test_overlong_scan();
    write_reg(REG_DISTANCE_THRESHOLD, 16'd100);
    write_reg(REG_MIN_RUN_LENGTH, 16'd4096);
    sender_idle = 1'b0;
    stall_mode = READY_PATTERN;
    stall_pat = 8'b1010_0110;
    scan_buf.delete();
    for (int i = 0; i < SCAN_LIMIT; i++)
      scan_buf.insert(scan_buf.size(), i >= 4000 ? 16'hFFFF : RANGE_W'(100 + i % 900));
    // beyond the limit: neither a break nor an extension
    scan_buf.insert(scan_buf.size(), 16'd0);
    scan_buf.insert(scan_buf.size(), 16'hFFFF);
    scan_buf.insert(scan_buf.size(), 16'd0);
    send_scan();
    wait_idle();
  endtask

  task automatic test_random_scans();
    int unsigned items, scans, phase, len, seg, t, peak_val, cap;
    logic [CFG_DATA_W-1:0] min_word;
    bit free_seg, noisy;
    items = 0;
    scans = 0;
    phase = 0;
    while (items < RANDOM_ITEMS || scans < RANDOM_SCANS) begin
      wait_idle();
      case (phase % 8)
        0: begin
          t = 32'(THRESHOLD_RESET);
          min_word = CFG_DATA_W'(MIN_RUN_RESET);
        end
        1: begin
          t = 0;
          min_word = 16'd2;
        end
        2: begin
          t = 65535;
          min_word = 16'd2;
        end
        3: begin
          t = $urandom_range(40000, 1000);
          min_word = CFG_DATA_W'($urandom_range(4, 2));
        end
        4: begin
          t = $urandom_range(65535, 0);
          min_word = 16'd1;
        end
        5: begin
          t = $urandom_range(20000, 0);
          min_word = CFG_DATA_W'($urandom_range(12, 6));
        end
        6: begin
          t = $urandom_range(5000, 0);
          min_word = 16'd0;
        end
        default: begin
          t = $urandom_range(65535, 0);
          min_word = $urandom_range(1, 0) ? 16'hFFFF : CFG_DATA_W'($urandom_range(4096, 100));
        end
      endcase
      write_reg(REG_DISTANCE_THRESHOLD, t[RANGE_W-1:0]);
      write_reg(REG_MIN_RUN_LENGTH, min_word);
      sender_idle = (phase % 3 != 2);
      stall_mode = ready_mode_t'((phase / 2) % 3);
      stall_pat = 8'($urandom_range(255, 1));
      burst_left = 0;
      repeat (6) begin
        scan_buf.delete();
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(500, 100) : $urandom_range(48, 1);
        noisy = ($urandom_range(4, 0) == 0);
        peak_val = $urandom_range(65535, t);
        cap = (min_run < 2) ? 5 : ((min_run > 37) ? 40 : min_run + 3);
        free_seg = 1'($urandom_range(1, 0));
        while (scan_buf.size() < len) begin
          seg = $urandom_range(cap, 1);
          repeat (seg) begin
            if (noisy)
              scan_buf.insert(scan_buf.size(),
                              $urandom_range(3, 0) == 0 ? RANGE_W'(t) :
                              RANGE_W'($urandom_range(65535, 0)));
            else if (free_seg || t == 0)
              case ($urandom_range(3, 0))
                0, 3: scan_buf.insert(scan_buf.size(), RANGE_W'(peak_val));
                1: scan_buf.insert(scan_buf.size(), RANGE_W'(t));
                default: scan_buf.insert(scan_buf.size(),
                                         RANGE_W'($urandom_range(65535, t)));
              endcase
            else
              scan_buf.insert(scan_buf.size(), RANGE_W'($urandom_range(t - 1, 0)));
          end
          free_seg = !free_seg;
        end
        while (scan_buf.size() > len) void'(scan_buf.pop_back());
        send_scan();
        items += len;
        scans++;
      end
      phase++;
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    smp.valid = 1'b0;
    smp.range_mm = '0;
    smp.last_sample = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_DISTANCE_THRESHOLD;
    cfg_ch.data = '0;
    res.ready = 1'b0;
    thr_mm = THRESHOLD_RESET;
    min_run = 32'(MIN_RUN_RESET);
    clear_scan_state();
    sender_idle = 1'b1;
    burst_left = 0;
    stall_mode = READY_RANDOM;
    stall_pat = 8'hFF;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_short_runs();
    test_threshold_extremes();
    test_earliest_tie();
    test_overlong_scan();
    test_random_scans();

    if (fail_count == 0 && gap_results_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
